[rtl/core/s4a_pkg.sv]
// Shared types, codes and constants of the SOCKS4a request parser.
package s4a_pkg;

    // Parser phases
    localparam logic [2:0] PH_HEADER   = 3'd0;
    localparam logic [2:0] PH_USERID   = 3'd1;
    localparam logic [2:0] PH_DOMAIN   = 3'd2;
    localparam logic [2:0] PH_ACCEPTED = 3'd3;
    localparam logic [2:0] PH_REJECTED = 3'd4;

    // Result kinds
    localparam logic [1:0] KIND_VERDICT = 2'd0;
    localparam logic [1:0] KIND_DOMAIN  = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;

    // Verdict codes
    localparam logic [1:0] V_ADDRESS = 2'd0;
    localparam logic [1:0] V_NAME    = 2'd1;
    localparam logic [1:0] V_REJECT  = 2'd2;

    // Protocol constants
    localparam logic [7:0]  SOCKS_VERSION  = 8'd4;
    localparam logic [7:0]  CMD_CONNECT    = 8'd1;
    localparam logic [31:0] LOW_ADDR_LIMIT = 32'd256;
    localparam logic [3:0]  HEADER_BYTES   = 4'd8;

    // Header byte positions
    localparam logic [3:0] HDR_VERSION  = 4'd0;
    localparam logic [3:0] HDR_COMMAND  = 4'd1;
    localparam logic [3:0] HDR_ADDR_POS = 4'd4;

    typedef struct packed {
        logic       new_connection;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  verdict;
        logic [15:0] target_port;
        logic [31:0] dest_address;
        logic [7:0]  out_byte;
    } t_out_item;

    typedef struct packed {
        logic [2:0]  phase;
        logic [3:0]  header_index;
        logic        version_command_ok;
        logic [15:0] port_value;
        logic [31:0] address_value;
        logic        name_seen;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase:              PH_HEADER,
        header_index:       4'd0,
        version_command_ok: 1'b1,
        port_value:         16'd0,
        address_value:      32'd0,
        name_seen:          1'b0
    };

endpackage

[rtl/core/s4a_if.sv]
// Valid/ready channel interfaces for request bytes and parser results.
interface s4a_in_if;
    logic              valid;
    logic              ready;
    s4a_pkg::t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface s4a_out_if;
    logic               valid;
    logic               ready;
    s4a_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/socks4a_request_parser.sv]
// SOCKS4a connect request parser: one client byte in, at most one result out.
// One request byte is taken per clock cycle while the skid register is empty;
// the parser state updates in the same cycle, and the result (verdict, domain
// byte or payload byte) is registered into the output register or, when that
// stays full, into its one-entry skid register. Input ready drops only when
// both are full; with the sink always ready the block sustains one byte per
// cycle indefinitely. A new-connection mark on a byte restarts parsing before
// that byte is taken. Reset is synchronous and active low.
module socks4a_request_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    s4a_in_if.sink            i_req,
    s4a_out_if.source         o_res
);

    s4a_pkg::t_state    r_state;
    s4a_pkg::t_state    step_state;
    logic               step_valid;
    s4a_pkg::t_out_item step_res;

    logic               r_out_v, n_out_v;
    s4a_pkg::t_out_item r_out, n_out;
    logic               r_skid_v, n_skid_v;
    s4a_pkg::t_out_item r_skid, n_skid;

    logic               accept;
    logic               out_take;

    s4a_step u_step (
        .i_state     (r_state),
        .i_item      (i_req.payload),
        .o_state     (step_state),
        .o_res_valid (step_valid),
        .o_res       (step_res)
    );

    assign i_req.ready   = !r_skid_v;
    assign accept        = i_req.valid && !r_skid_v;
    assign out_take      = r_out_v && o_res.ready;
    assign o_res.valid   = r_out_v;
    assign o_res.payload = r_out;

    // drain the output register, refill from skid or from a new result
    always_comb begin
        n_out_v  = r_out_v;
        n_out    = r_out;
        n_skid_v = r_skid_v;
        n_skid   = r_skid;
        if (out_take) begin
            if (r_skid_v) begin
                n_out    = r_skid;
                n_skid_v = 1'b0;
            end else begin
                n_out_v = 1'b0;
            end
        end
        if (accept && step_valid) begin
            if (!n_out_v) begin
                n_out_v = 1'b1;
                n_out   = step_res;
            end else begin
                n_skid_v = 1'b1;
                n_skid   = step_res;
            end
        end
    end

    // hold parser state and output control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= s4a_pkg::STATE_RESET;
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (accept) r_state <= step_state;
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

endmodule

[rtl/core/s4a_step.sv]
// Next-state and result logic for one request byte.
module s4a_step (
    input  s4a_pkg::t_state    i_state,
    input  s4a_pkg::t_in_item  i_item,
    output s4a_pkg::t_state    o_state,
    output logic               o_res_valid,
    output s4a_pkg::t_out_item o_res
);

    s4a_pkg::t_state st;
    s4a_pkg::t_state nx;
    logic [7:0]      b;
    logic [3:0]      idx_inc;

    always_comb begin
        // restart on a new connection before taking the byte
        st          = i_item.new_connection ? s4a_pkg::STATE_RESET : i_state;
        b           = i_item.data_byte;
        nx          = st;
        idx_inc     = st.header_index + 4'd1;
        o_res_valid = 1'b0;
        o_res       = '0;

        unique case (st.phase)
            s4a_pkg::PH_HEADER: begin
                // collect version, command, port and address
                if (st.header_index == s4a_pkg::HDR_VERSION) begin
                    if (b != s4a_pkg::SOCKS_VERSION) nx.version_command_ok = 1'b0;
                end else if (st.header_index == s4a_pkg::HDR_COMMAND) begin
                    if (b != s4a_pkg::CMD_CONNECT) nx.version_command_ok = 1'b0;
                end else if (st.header_index < s4a_pkg::HDR_ADDR_POS) begin
                    nx.port_value = {st.port_value[7:0], b};
                end else begin
                    nx.address_value = {st.address_value[23:0], b};
                end
                nx.header_index = idx_inc;
                if (idx_inc >= s4a_pkg::HEADER_BYTES) nx.phase = s4a_pkg::PH_USERID;
            end
            s4a_pkg::PH_USERID: begin
                // skip user id; at its end go to domain or give the verdict
                if (b == 8'd0) begin
                    if (st.address_value < s4a_pkg::LOW_ADDR_LIMIT) begin
                        nx.phase = s4a_pkg::PH_DOMAIN;
                    end else begin
                        o_res_valid          = 1'b1;
                        o_res.kind           = s4a_pkg::KIND_VERDICT;
                        o_res.verdict        = st.version_command_ok ?
                                               s4a_pkg::V_ADDRESS : s4a_pkg::V_REJECT;
                        o_res.target_port    = st.port_value;
                        o_res.dest_address   = st.address_value;
                        nx.phase             = st.version_command_ok ?
                                               s4a_pkg::PH_ACCEPTED : s4a_pkg::PH_REJECTED;
                    end
                end
            end
            s4a_pkg::PH_DOMAIN: begin
                if (b == 8'd0) begin
                    // end of name: decide
                    o_res_valid        = 1'b1;
                    o_res.kind         = s4a_pkg::KIND_VERDICT;
                    o_res.target_port  = st.port_value;
                    o_res.dest_address = st.address_value;
                    if (!st.version_command_ok) begin
                        o_res.verdict = s4a_pkg::V_REJECT;
                        nx.phase      = s4a_pkg::PH_REJECTED;
                    end else begin
                        o_res.verdict = st.name_seen ? s4a_pkg::V_NAME : s4a_pkg::V_ADDRESS;
                        nx.phase      = s4a_pkg::PH_ACCEPTED;
                    end
                end else begin
                    // emit name bytes only for a good request
                    nx.name_seen = 1'b1;
                    if (st.version_command_ok) begin
                        o_res_valid    = 1'b1;
                        o_res.kind     = s4a_pkg::KIND_DOMAIN;
                        o_res.out_byte = b;
                    end
                end
            end
            s4a_pkg::PH_ACCEPTED: begin
                // pass payload through
                o_res_valid    = 1'b1;
                o_res.kind     = s4a_pkg::KIND_PAYLOAD;
                o_res.out_byte = b;
            end
            default: begin
                // rejected or unused phase: drop the byte
                o_res_valid = 1'b0;
            end
        endcase

        o_state = nx;
    end

endmodule

[verif/s4a_result_checker.sv]
// Result checker for the SOCKS4a request parser: predicts each result and compares in order.
module s4a_result_checker
    import s4a_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    s4a_in_if    i_req,
    s4a_out_if   i_res,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    t_state    conn;
    t_out_item expected_results[$];
    int        fails = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic t_state fresh_connection();
        t_state s;
        s.phase              = PH_HEADER;
        s.header_index       = '0;
        s.version_command_ok = 1'b1;
        s.port_value         = '0;
        s.address_value      = '0;
        s.name_seen          = 1'b0;
        return s;
    endfunction

    // Close the request with a verdict and park in the matching terminal phase
    function automatic t_out_item close_request(input logic [1:0] verdict);
        t_out_item r;
        r              = '0;
        r.kind         = KIND_VERDICT;
        r.verdict      = verdict;
        r.target_port  = conn.port_value;
        r.dest_address = conn.address_value;
        conn.phase     = (verdict == V_REJECT) ? PH_REJECTED : PH_ACCEPTED;
        return r;
    endfunction

    // Advance the connection by one byte; return 1 when the byte yields a result
    function automatic bit parse_request_byte(input t_in_item req, output t_out_item res);
        logic [7:0] b;
        b   = req.data_byte;
        res = '0;
        if (req.new_connection)
            conn = fresh_connection();
        case (conn.phase)
            PH_HEADER: begin
                if (conn.header_index == HDR_VERSION) begin
                    if (b != SOCKS_VERSION)
                        conn.version_command_ok = 1'b0;
                end else if (conn.header_index == HDR_COMMAND) begin
                    if (b != CMD_CONNECT)
                        conn.version_command_ok = 1'b0;
                end else if (conn.header_index < HDR_ADDR_POS) begin
                    conn.port_value = {conn.port_value[7:0], b};
                end else begin
                    conn.address_value = {conn.address_value[23:0], b};
                end
                conn.header_index = conn.header_index + 4'd1;
                if (conn.header_index >= HEADER_BYTES)
                    conn.phase = PH_USERID;
                return 1'b0;
            end
            PH_USERID: begin
                if (b != 8'd0)
                    return 1'b0;
                // A low address announces a domain name after the user id
                if (conn.address_value < LOW_ADDR_LIMIT) begin
                    conn.phase = PH_DOMAIN;
                    return 1'b0;
                end
                res = close_request(conn.version_command_ok ? V_ADDRESS : V_REJECT);
                return 1'b1;
            end
            PH_DOMAIN: begin
                if (b == 8'd0) begin
                    if (!conn.version_command_ok)
                        res = close_request(V_REJECT);
                    else if (conn.name_seen)
                        res = close_request(V_NAME);
                    else
                        res = close_request(V_ADDRESS);
                    return 1'b1;
                end
                conn.name_seen = 1'b1;
                // Hold back domain bytes of a bad request
                if (!conn.version_command_ok)
                    return 1'b0;
                res.kind     = KIND_DOMAIN;
                res.out_byte = b;
                return 1'b1;
            end
            PH_ACCEPTED: begin
                res.kind     = KIND_PAYLOAD;
                res.out_byte = b;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_out_item got;
        t_out_item want;
        t_out_item fresh;
        if (!i_rst_n) begin
            conn = fresh_connection();
            expected_results.delete();
        end else begin
            // Match an accepted result against the oldest prediction
            if (i_res.valid && i_res.ready) begin
                got = i_res.payload;
                if (expected_results.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: unexpected kind %0d verdict %0d port %h addr %h byte %h",
                                 $realtime, got.kind, got.verdict, got.target_port,
                                 got.dest_address, got.out_byte);
                end else begin
                    want = expected_results.pop_front();
                    if (got.kind !== want.kind || got.verdict !== want.verdict ||
                        got.target_port !== want.target_port ||
                        got.dest_address !== want.dest_address ||
                        got.out_byte !== want.out_byte) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("%0t: result mismatch", $realtime);
                            $display("  expected kind %0d verdict %0d port %h addr %h byte %h",
                                     want.kind, want.verdict, want.target_port,
                                     want.dest_address, want.out_byte);
                            $display("  actual   kind %0d verdict %0d port %h addr %h byte %h",
                                     got.kind, got.verdict, got.target_port,
                                     got.dest_address, got.out_byte);
                        end
                    end
                end
            end
            // Predict what the accepted request byte produces
            if (i_req.valid && i_req.ready) begin
                if (parse_request_byte(i_req.payload, fresh))
                    expected_results.push_back(fresh);
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_results.size();
    end

endmodule

[verif/socks4a_request_parser_tb.sv]
// Testbench top for the SOCKS4a request parser: clock, reset, request stimulus and verdict.
module socks4a_request_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import s4a_pkg::*;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending_count;
    bit   steady = 1'b0;
    int   bytes_sent = 0;

    s4a_in_if  req_if ();
    s4a_out_if res_if ();

    socks4a_request_parser u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    s4a_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_res        (res_if),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    always #6 i_clk = ~i_clk;

    // Stall the result side now and then, except during the steady stretch
    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            res_if.ready <= steady || ($urandom_range(99) >= 10);
        end
    end

    // Offer one request byte and hold it until the parser takes it
    task automatic send_byte(input logic nc, input logic [7:0] b);
        t_in_item item;
        item.new_connection = nc;
        item.data_byte      = b;
        while (!steady && $urandom_range(99) < 10) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= item;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // Send the first count header bytes, opening a fresh connection
    task automatic send_header(input logic [7:0] ver, input logic [7:0] cmd,
                               input logic [15:0] port, input logic [31:0] addr,
                               input int count);
        logic [7:0] hdr [8];
        hdr = '{ver, cmd, port[15:8], port[7:0],
                addr[31:24], addr[23:16], addr[15:8], addr[7:0]};
        for (int i = 0; i < count; i++)
            send_byte(i == 0, hdr[i]);
    endtask

    // Send a zero-terminated string of random nonzero characters
    task automatic send_string(input int len);
        for (int i = 0; i < len; i++)
            send_byte(1'b0, 8'($urandom_range(1, 255)));
        send_byte(1'b0, 8'd0);
    endtask

    // Request with random content, mostly well-formed; a few are cut short
    task automatic send_random_request();
        logic [7:0]  ver;
        logic [7:0]  cmd;
        logic [15:0] port;
        logic [31:0] addr;
        int          tail;
        ver = ($urandom_range(9) == 0) ? 8'($urandom) : SOCKS_VERSION;
        cmd = ($urandom_range(9) == 0) ? 8'($urandom) : CMD_CONNECT;
        case ($urandom_range(7))
            0:       port = 16'h0000;
            1:       port = 16'hFFFF;
            default: port = 16'($urandom);
        endcase
        case ($urandom_range(9))
            0:       addr = 32'd0;
            1:       addr = 32'd255;
            2:       addr = 32'd256;
            3:       addr = 32'hFFFF_FFFF;
            4, 5, 6: addr = 32'($urandom_range(0, 255));
            default: addr = $urandom;
        endcase
        if ($urandom_range(9) == 0) begin
            send_header(ver, cmd, port, addr, $urandom_range(1, 7));
            return;
        end
        send_header(ver, cmd, port, addr, 8);
        send_string($urandom_range(0, 5));
        if (addr < LOW_ADDR_LIMIT)
            send_string(($urandom_range(9) < 3) ? 0 : $urandom_range(1, 8));
        // Trailing bytes: payload after an accept, dropped after a reject
        tail = (ver == SOCKS_VERSION && cmd == CMD_CONNECT) ? $urandom_range(0, 6)
                                                           : $urandom_range(0, 1);
        for (int i = 0; i < tail; i++)
            send_byte(1'b0, 8'($urandom));
    endtask

    // Stimulus and verdict
    initial begin
        int reqs;
        req_if.valid   <= 1'b0;
        req_if.payload <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Extreme port, address zero, empty user id and empty domain, then payload
        send_header(SOCKS_VERSION, CMD_CONNECT, 16'hFFFF, 32'd0, 8);
        send_byte(1'b0, 8'd0);
        send_byte(1'b0, 8'd0);
        send_byte(1'b0, 8'hFF);
        // Bad version and command with the top address, then a dropped byte
        send_header(8'd3, 8'd2, 16'h0000, 32'hFFFF_FFFF, 8);
        send_byte(1'b0, 8'd0);
        send_byte(1'b0, 8'h05);
        // Named destination, then a zero payload byte
        send_header(SOCKS_VERSION, CMD_CONNECT, 16'h1234, 32'd255, 8);
        send_string(1);
        send_string(1);
        send_byte(1'b0, 8'h00);

        // Random requests mixed with noise, with a stretch of no idling
        reqs = 0;
        while (bytes_sent < 1900) begin
            steady <= (reqs >= 55 && reqs < 85);
            if ($urandom_range(9) == 0) begin
                repeat ($urandom_range(1, 6))
                    send_byte($urandom_range(19) == 0, 8'($urandom));
            end else begin
                send_random_request();
            end
            reqs++;
        end
        req_if.valid <= 1'b0;
        steady       <= 1'b0;

        // Drain the outstanding results, then allow for stray ones
        do @(posedge i_clk); while (pending_count != 0);
        repeat (16) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0)
            $display("socks4a_request_parser regression: pass");
        else
            $display("socks4a_request_parser regression: fail");
        $finish;
    end

    // Watchdog
    initial begin
        #(2_000_000);
        $display("socks4a_request_parser regression: fail");
        $finish;
    end

endmodule
